/* design/ccm_pkg.sv */
// shared types and constants for the complex correlation magnitude block
`timescale 1ns / 1ps

package ccm_pkg;

   // default longest block, in sample pairs
   localparam int unsigned DEF_MAX_ITEMS = 4096;

   localparam int unsigned SAMPLE_W = 16;
   // mean of the conjugate products: magnitude never above 2^31
   localparam int unsigned MEAN_W   = 33;
   localparam int unsigned PROD_W   = 2 * MEAN_W;
   localparam int unsigned SQ_W     = 64;
   // radicand is the sum of squares shifted down by 30
   localparam int unsigned RAD_SHIFT = 30;
   localparam int unsigned RAD_W    = SQ_W - RAD_SHIFT;
   localparam int unsigned ROOT_W   = RAD_W / 2;
   localparam int unsigned REM_W    = ROOT_W + 3;
   localparam int unsigned MAG_W    = 16;
   localparam int unsigned MAC_STEPS  = 5;
   localparam int unsigned SQ_STEPS   = 3;
   localparam int unsigned ROOT_STEPS = ROOT_W;
   localparam int unsigned STEP_W   = $clog2(ROOT_STEPS);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MAC,
      ST_DIV_RE,
      ST_WAIT_RE,
      ST_DIV_IM,
      ST_WAIT_IM,
      ST_SQUARE,
      ST_ROOT,
      ST_OUT
   } ccm_state_type;

endpackage

/* design/ccm_udiv.sv */
// iterative restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps

module ccm_udiv #(
   parameter int unsigned NUM_W = 45,
   parameter int unsigned DEN_W = 13
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] numer,
   input  logic [DEN_W-1:0] denom,
   output logic             done,
   output logic [NUM_W-1:0] quot
);

   localparam int unsigned CNT_W = $clog2(NUM_W + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [NUM_W-1:0] quot_ff, quot_in;
   logic [DEN_W:0]   shifted;
   logic [DEN_W:0]   diff;
   logic             fits;

   // partial remainder takes the next dividend bit, quotient bit shifts in below
   assign shifted = {rem_ff, quot_ff[NUM_W-1]};
   assign diff    = shifted - {1'b0, denom};
   assign fits    = shifted >= {1'b0, denom};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quot_in = quot_ff;
      if (start && !busy_ff) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(NUM_W);
         rem_in  = '0;
         quot_in = numer;
      end else if (busy_ff) begin
         rem_in  = fits ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
         quot_in = {quot_ff[NUM_W-2:0], fits};
         cnt_in  = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule

/* design/complex_correlation_magnitude.sv */
// Complex cross-correlation magnitude: accumulates x * conj(y) over a block of Q15 sample
// pairs and, on the last pair of a block (or when the count reaches MAX_ITEMS), gives
// floor(|mean|) as unsigned Q1.15 saturated at 65535, then clears its sums and count.
// One 33x33 multiplier does every product, so each sample pair passes through the ready
// state that takes the beat, four products and the final accumulate, and the input is not
// ready again until the pair is done. A pair that ends a block adds the two divisions of the
// restoring divider (ACC_W = clog2(MAX_ITEMS) + 33, so 45 by default), the squaring, the
// square root and the load of the output register once it is free. A finished result waits
// in the output register while new pairs are taken.
`timescale 1ns / 1ps

module complex_correlation_magnitude #(
   parameter int unsigned MAX_ITEMS = ccm_pkg::DEF_MAX_ITEMS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // x_re, x_im, y_re, y_im
   input  logic        req_tlast,   // last
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata    // magnitude
);

   import ccm_pkg::*;

   localparam int unsigned CNT_W = $clog2(MAX_ITEMS + 1);
   localparam int unsigned ACC_W = $clog2(MAX_ITEMS) + 33;

   ccm_state_type state_ff, state_in;

   logic [STEP_W-1:0]        step_ff, step_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic signed [ACC_W-1:0]  acc_re_ff, acc_re_in;
   logic signed [ACC_W-1:0]  acc_im_ff, acc_im_in;
   logic signed [SAMPLE_W-1:0] x_re_ff, x_im_ff, y_re_ff, y_im_ff;
   logic                     last_ff;
   logic signed [MEAN_W-1:0] mean_re_ff, mean_re_in;
   logic signed [MEAN_W-1:0] mean_im_ff, mean_im_in;
   logic signed [PROD_W-1:0] prod_ff;
   logic [SQ_W-1:0]          sq_ff, sq_in;
   logic [RAD_W-1:0]         rad_ff, rad_in;
   logic [REM_W-1:0]         rem_ff, rem_in;
   logic [ROOT_W-1:0]        root_ff, root_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [MAG_W-1:0]         rsp_data_ff, rsp_data_in;

   logic                     accept;
   logic signed [MEAN_W-1:0] mul_a, mul_b;
   logic signed [ACC_W-1:0]  add_base, add_term, add_sum;
   logic [CNT_W-1:0]         count_next;
   logic                     block_end;
   logic                     div_start, div_done;
   logic [ACC_W-1:0]         div_num, div_quot;
   logic signed [ACC_W-1:0]  div_src;
   logic signed [MEAN_W-1:0] div_mean;
   logic [REM_W-1:0]         rem_sh, trial;
   logic                     rem_fits;
   logic                     out_free;

   assign accept   = req_tvalid && req_tready;
   assign out_free = !rsp_valid_ff || rsp_tready;

   // shared multiplier, always registered
   always_comb begin
      mul_a = MEAN_W'(x_re_ff);
      mul_b = MEAN_W'(y_re_ff);
      if (state_ff == ST_SQUARE) begin
         mul_a = (step_ff == '0) ? mean_re_ff : mean_im_ff;
         mul_b = mul_a;
      end else begin
         unique case (step_ff)
            STEP_W'(0): begin
               mul_a = MEAN_W'(x_re_ff);
               mul_b = MEAN_W'(y_re_ff);
            end
            STEP_W'(1): begin
               mul_a = MEAN_W'(x_im_ff);
               mul_b = MEAN_W'(y_im_ff);
            end
            STEP_W'(2): begin
               mul_a = MEAN_W'(x_im_ff);
               mul_b = MEAN_W'(y_re_ff);
            end
            default: begin
               mul_a = MEAN_W'(x_re_ff);
               mul_b = MEAN_W'(y_im_ff);
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
   end

   // one accumulator adder: real sum on steps 1 and 2, imaginary on 3 and 4
   assign add_base = (step_ff <= STEP_W'(2)) ? acc_re_ff : acc_im_ff;
   assign add_term = (step_ff == STEP_W'(MAC_STEPS - 1)) ? -prod_ff[ACC_W-1:0]
                                                         : prod_ff[ACC_W-1:0];
   assign add_sum  = add_base + add_term;

   assign count_next = count_ff + CNT_W'(1);
   assign block_end  = last_ff || (count_next == CNT_W'(MAX_ITEMS));

   // divider takes magnitudes, sign restored on the way out
   assign div_src   = (state_ff == ST_DIV_RE || state_ff == ST_WAIT_RE) ? acc_re_ff : acc_im_ff;
   assign div_num   = div_src[ACC_W-1] ? ACC_W'(-div_src) : ACC_W'(div_src);
   assign div_start = (state_ff == ST_DIV_RE) || (state_ff == ST_DIV_IM);
   assign div_mean  = div_src[ACC_W-1] ? -$signed(div_quot[MEAN_W-1:0])
                                       : $signed(div_quot[MEAN_W-1:0]);

   ccm_udiv #(
      .NUM_W (ACC_W),
      .DEN_W (CNT_W)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .numer (div_num),
      .denom (count_ff),
      .done  (div_done),
      .quot  (div_quot)
   );

   // digit-by-digit square root, two radicand bits per step
   assign rem_sh   = {rem_ff[REM_W-3:0], rad_ff[RAD_W-1 -: 2]};
   assign trial    = REM_W'({root_ff, 2'b01});
   assign rem_fits = rem_sh >= trial;

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      count_in     = count_ff;
      acc_re_in    = acc_re_ff;
      acc_im_in    = acc_im_ff;
      mean_re_in   = mean_re_ff;
      mean_im_in   = mean_im_ff;
      sq_in        = sq_ff;
      rad_in       = rad_ff;
      rem_in       = rem_ff;
      root_in      = root_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      req_tready   = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (accept) begin
               state_in = ST_MAC;
               step_in  = '0;
            end
         end
         ST_MAC: begin
            step_in = step_ff + STEP_W'(1);
            if (step_ff != '0) begin
               if (step_ff <= STEP_W'(2)) begin
                  acc_re_in = add_sum;
               end else begin
                  acc_im_in = add_sum;
               end
            end
            if (step_ff == STEP_W'(MAC_STEPS - 1)) begin
               count_in = count_next;
               step_in  = '0;
               state_in = block_end ? ST_DIV_RE : ST_IDLE;
            end
         end
         ST_DIV_RE: begin
            state_in = ST_WAIT_RE;
         end
         ST_WAIT_RE: begin
            if (div_done) begin
               mean_re_in = div_mean;
               state_in   = ST_DIV_IM;
            end
         end
         ST_DIV_IM: begin
            state_in = ST_WAIT_IM;
         end
         ST_WAIT_IM: begin
            if (div_done) begin
               mean_im_in = div_mean;
               state_in   = ST_SQUARE;
               step_in    = '0;
            end
         end
         ST_SQUARE: begin
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(1)) begin
               sq_in = prod_ff[SQ_W-1:0];
            end
            if (step_ff == STEP_W'(SQ_STEPS - 1)) begin
               sq_in    = sq_ff + prod_ff[SQ_W-1:0];
               rad_in   = RAD_W'((sq_ff + prod_ff[SQ_W-1:0]) >> RAD_SHIFT);
               rem_in   = '0;
               root_in  = '0;
               step_in  = '0;
               state_in = ST_ROOT;
            end
         end
         ST_ROOT: begin
            step_in = step_ff + STEP_W'(1);
            rad_in  = {rad_ff[RAD_W-3:0], 2'b00};
            rem_in  = rem_fits ? rem_sh - trial : rem_sh;
            root_in = {root_ff[ROOT_W-2:0], rem_fits};
            if (step_ff == STEP_W'(ROOT_STEPS - 1)) begin
               step_in  = '0;
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = root_ff[ROOT_W-1] ? {MAG_W{1'b1}} : root_ff[MAG_W-1:0];
               acc_re_in    = '0;
               acc_im_in    = '0;
               count_in     = '0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         count_ff     <= '0;
         acc_re_ff    <= '0;
         acc_im_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         count_ff     <= count_in;
         acc_re_ff    <= acc_re_in;
         acc_im_ff    <= acc_im_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         x_re_ff <= req_tdata[15:0];
         x_im_ff <= req_tdata[31:16];
         y_re_ff <= req_tdata[47:32];
         y_im_ff <= req_tdata[63:48];
         last_ff <= req_tlast;
      end
      mean_re_ff  <= mean_re_in;
      mean_im_ff  <= mean_im_in;
      sq_ff       <= sq_in;
      rad_ff      <= rad_in;
      rem_ff      <= rem_in;
      root_ff     <= root_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
